@@ sv/cbpm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbpm_pkg
// Types, constants and codes shared by the chained buffer pool manager.
// ----------------------------------------------------------------------------
`default_nettype none
package cbpm_pkg;

  localparam int unsigned NumBuffers = 8;
  localparam int unsigned BufBytes   = 32;
  localparam int unsigned WordCap    = 32;
  localparam int unsigned HW         = $clog2(NumBuffers);
  localparam int unsigned BW         = $clog2(BufBytes);
  localparam int unsigned AW         = HW + BW;

  typedef enum logic [1:0] {
    CMD_FETCH  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_COMMIT = 2'd2,
    CMD_PLEN   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_BADH   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BACK,
    S_FWD,
    S_RD,
    S_BYTE,
    S_FREE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] handle;
    logic       handle_valid;
    logic [5:0] position;
    logic [7:0] byte_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  new_handle;
    logic [5:0]  new_position;
    logic [63:0] data_word;
    logic [3:0]  data_bytes;
    logic [7:0]  prev_length;
    logic        last;
  } res_t;

  // byte store port
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

@@ sv/cbpm_byte_ram.sv @@
// ----------------------------------------------------------------------------
// cbpm_byte_ram
// Byte store of the pool: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module cbpm_byte_ram (
  input  wire logic                clk_i,
  input  wire cbpm_pkg::mem_req_t  req_i,
  output logic [7:0]               rdata_o
);
  logic [7:0] mem [cbpm_pkg::NumBuffers*cbpm_pkg::BufBytes];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end
endmodule
`default_nettype wire

@@ sv/chained_buffer_pool_manager_unit.sv @@
// ----------------------------------------------------------------------------
// chained_buffer_pool_manager_unit
// Pool of linked byte buffers with a free list, driven by commands.
// ----------------------------------------------------------------------------
// One command is taken at a rising edge with start_i high and busy_o low.
// Fetch, append and bad-handle answers are formed in the DONE state and
// registered onto the ports; busy_o falls as the answer comes out, so the
// block cannot take a new command before then. Previous length walks the
// chain backwards, one link a cycle. Commit walks back, then forward over the
// chain, reading the byte store one byte a cycle within each buffer from its
// registered read port, then frees one buffer a cycle. Each full word leaves
// one word later than it is assembled so that the final word can carry last;
// a partial final word follows in the first freeing cycle.
// Results come with valid_o for one cycle and cannot be held off.
`default_nettype none
module chained_buffer_pool_manager_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire cbpm_pkg::cmd_t  cmd_i,
  output logic                 busy_o,
  output logic                 valid_o,
  output cbpm_pkg::res_t       res_o
);
  localparam int unsigned N  = cbpm_pkg::NumBuffers;
  localparam int unsigned HW = cbpm_pkg::HW;
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned TW = $clog2(cbpm_pkg::WordCap * 8 + 1);
  localparam int unsigned FW = $clog2(cbpm_pkg::BufBytes + 1);

  // link and fill tables
  logic [HW-1:0] next_q [N];
  logic [N-1:0]  next_ok_q;
  logic [HW-1:0] prev_q [N];
  logic [N-1:0]  prev_ok_q;
  logic [FW-1:0] fill_q [N];
  logic [N-1:0]  alloc_q;
  logic [HW-1:0] fhead_q;
  logic          fok_q;

  cbpm_pkg::state_e st_q, st_d;
  cbpm_pkg::cmd_t   c_q;
  logic [HW-1:0]    cur_q;
  logic [N-1:0]     seen_q;
  logic [HW-1:0]    order_q [N];
  logic [CW-1:0]    cnt_q, idx_q;
  logic [FW-1:0]    bi_q;
  logic [TW-1:0]    total_q;
  logic [63:0]      word_q;
  logic [3:0]       nb_q;
  logic [HW-1:0]    steps_q;
  logic             rvld_q;
  logic             pend_q;
  logic [63:0]      pend_w_q;
  logic             tail_q;

  cbpm_pkg::res_t   res_d;
  logic             vld_d;

  cbpm_pkg::mem_req_t mreq;
  logic [7:0]         rdata;

  cbpm_byte_ram u_ram (.clk_i(clk_i), .req_i(mreq), .rdata_o(rdata));

  logic          hok;
  logic [HW-1:0] h;
  logic [HW-1:0] pl, nl;
  logic          back_go, fwd_go, byte_go, cap_ok;

  assign h       = c_q.handle[HW-1:0];
  assign hok     = ({{(8-HW){1'b0}}, h} == 8'(c_q.handle)) && alloc_q[h];
  assign pl      = prev_q[cur_q];
  assign nl      = next_q[cur_q];
  assign back_go = prev_ok_q[cur_q] && alloc_q[pl] && !seen_q[pl];
  assign fwd_go  = next_ok_q[cur_q] && alloc_q[nl] && !seen_q[nl] && (cnt_q < CW'(N));
  assign cap_ok  = total_q < TW'(cbpm_pkg::WordCap * 8);
  assign byte_go = (bi_q < fill_q[cur_q]) && cap_ok;
  assign busy_o  = (st_q != cbpm_pkg::S_IDLE);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      cbpm_pkg::S_IDLE: if (start_i) st_d = cbpm_pkg::S_DONE;
      cbpm_pkg::S_DONE: begin
        if (c_q.command == cbpm_pkg::CMD_COMMIT && hok) st_d = cbpm_pkg::S_BACK;
        else if (c_q.command == cbpm_pkg::CMD_PLEN && hok) st_d = cbpm_pkg::S_BACK;
        else st_d = cbpm_pkg::S_IDLE;
      end
      cbpm_pkg::S_BACK: begin
        if (!back_go) st_d = (c_q.command == cbpm_pkg::CMD_PLEN) ? cbpm_pkg::S_IDLE
                                                                   : cbpm_pkg::S_RD;
      end
      cbpm_pkg::S_RD: st_d = cbpm_pkg::S_BYTE;
      cbpm_pkg::S_BYTE: if (!byte_go && !rvld_q) st_d = cbpm_pkg::S_FWD;
      cbpm_pkg::S_FWD: st_d = fwd_go ? cbpm_pkg::S_RD : cbpm_pkg::S_FREE;
      cbpm_pkg::S_FREE: if (idx_q == cnt_q - CW'(1)) st_d = cbpm_pkg::S_IDLE;
      default: st_d = cbpm_pkg::S_IDLE;
    endcase
  end

  // result of the current cycle, registered onto the ports
  always_comb begin
    vld_d = 1'b0;
    res_d = '0;
    case (st_q)
      cbpm_pkg::S_DONE: begin
        res_d.last = 1'b1;
        if (c_q.command == cbpm_pkg::CMD_FETCH) begin
          vld_d = 1'b1;
          if (c_q.handle_valid && !hok) res_d.status = cbpm_pkg::ST_BADH;
          else if (!fok_q) res_d.status = cbpm_pkg::ST_NOFREE;
          else res_d.new_handle = 3'(fhead_q);
        end else if (!hok) begin
          vld_d = 1'b1;
          res_d.status = cbpm_pkg::ST_BADH;
        end else if (c_q.command == cbpm_pkg::CMD_APPEND) begin
          vld_d = 1'b1;
          if (c_q.position >= 6'(cbpm_pkg::BufBytes)) begin
            if (!fok_q) res_d.status = cbpm_pkg::ST_NOFREE;
            else begin
              res_d.new_handle   = 3'(fhead_q);
              res_d.new_position = 6'd1;
            end
          end else begin
            res_d.new_handle   = c_q.handle;
            res_d.new_position = c_q.position + 6'd1;
          end
        end
      end
      cbpm_pkg::S_BACK: begin
        if (!back_go && c_q.command == cbpm_pkg::CMD_PLEN) begin
          vld_d = 1'b1;
          res_d.last = 1'b1;
          res_d.prev_length = (16'(steps_q) * 16'(cbpm_pkg::BufBytes) > 16'd255)
            ? 8'd255 : 8'(16'(steps_q) * 16'(cbpm_pkg::BufBytes));
        end
      end
      cbpm_pkg::S_BYTE: begin
        // a new full word releases the one held before it
        if (rvld_q && nb_q == 4'd7 && pend_q) begin
          vld_d = 1'b1;
          res_d.data_word  = pend_w_q;
          res_d.data_bytes = 4'd8;
        end
      end
      cbpm_pkg::S_FWD: begin
        if (!fwd_go) begin
          vld_d = 1'b1;
          if (pend_q) begin
            res_d.data_word  = pend_w_q;
            res_d.data_bytes = 4'd8;
            res_d.last       = (nb_q == 4'd0);
          end else begin
            res_d.data_word  = word_q;
            res_d.data_bytes = nb_q;
            res_d.last       = 1'b1;
          end
        end
      end
      cbpm_pkg::S_FREE: begin
        // partial final word after the held full word
        if (tail_q) begin
          vld_d = 1'b1;
          res_d.last       = 1'b1;
          res_d.data_word  = word_q;
          res_d.data_bytes = nb_q;
        end
      end
      default: ;
    endcase
  end

  // byte store requests
  always_comb begin
    mreq       = '0;
    mreq.raddr = {cur_q, bi_q[cbpm_pkg::BW-1:0]};
    if (st_q == cbpm_pkg::S_DONE && c_q.command == cbpm_pkg::CMD_APPEND && hok) begin
      if (c_q.position >= 6'(cbpm_pkg::BufBytes)) begin
        mreq.we    = fok_q;
        mreq.waddr = {fhead_q, {cbpm_pkg::BW{1'b0}}};
      end else begin
        mreq.we    = 1'b1;
        mreq.waddr = {h, c_q.position[cbpm_pkg::BW-1:0]};
      end
      mreq.wdata = c_q.byte_value;
    end
  end

  // sequencer and tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= cbpm_pkg::S_IDLE;
      valid_o   <= 1'b0;
      res_o     <= '0;
      for (int i = 0; i < N; i++) begin
        next_q[i] <= HW'((i + 1) % N);
        prev_q[i] <= '0;
        fill_q[i] <= '0;
        order_q[i] <= '0;
      end
      next_ok_q <= {1'b0, {(N-1){1'b1}}};
      prev_ok_q <= '0;
      alloc_q   <= '0;
      fhead_q   <= '0;
      fok_q     <= 1'b1;
      c_q       <= '0;
      cur_q     <= '0;
      seen_q    <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      bi_q      <= '0;
      total_q   <= '0;
      word_q    <= '0;
      nb_q      <= '0;
      steps_q   <= '0;
      rvld_q    <= 1'b0;
      pend_q    <= 1'b0;
      pend_w_q  <= '0;
      tail_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      valid_o <= vld_d;
      res_o   <= res_d;
      rvld_q  <= 1'b0;
      case (st_q)
        cbpm_pkg::S_IDLE: if (start_i) c_q <= cmd_i;
        cbpm_pkg::S_DONE: begin
          cur_q   <= h;
          seen_q  <= N'(1) << h;
          steps_q <= '0;
          cnt_q   <= '0;
          total_q <= '0;
          nb_q    <= '0;
          word_q  <= '0;
          bi_q    <= '0;
          pend_q  <= 1'b0;
          tail_q  <= 1'b0;
          if (c_q.command == cbpm_pkg::CMD_FETCH) begin
            if (!(c_q.handle_valid && !hok) && fok_q) begin
              fhead_q <= next_q[fhead_q];
              fok_q   <= next_ok_q[fhead_q];
              alloc_q[fhead_q]   <= 1'b1;
              fill_q[fhead_q]    <= '0;
              next_ok_q[fhead_q] <= 1'b0;
              prev_ok_q[fhead_q] <= c_q.handle_valid;
              if (c_q.handle_valid) begin
                next_q[h] <= fhead_q;
                next_ok_q[h] <= 1'b1;
                prev_q[fhead_q] <= h;
              end
            end
          end else if (hok && c_q.command == cbpm_pkg::CMD_APPEND) begin
            if (c_q.position >= 6'(cbpm_pkg::BufBytes)) begin
              if (fok_q) begin
                fhead_q <= next_q[fhead_q];
                fok_q   <= next_ok_q[fhead_q];
                alloc_q[fhead_q]   <= 1'b1;
                fill_q[fhead_q]    <= FW'(1);
                next_ok_q[fhead_q] <= 1'b0;
                prev_ok_q[fhead_q] <= 1'b1;
                prev_q[fhead_q]    <= h;
                next_q[h]    <= fhead_q;
                next_ok_q[h] <= 1'b1;
              end
            end else begin
              if (fill_q[h] < FW'(c_q.position) + FW'(1))
                fill_q[h] <= FW'(c_q.position) + FW'(1);
            end
          end
        end
        cbpm_pkg::S_BACK: begin
          if (back_go) begin
            cur_q   <= pl;
            seen_q  <= seen_q | (N'(1) << pl);
            steps_q <= steps_q + HW'(1);
          end else begin
            seen_q <= N'(1) << cur_q;
            if (c_q.command != cbpm_pkg::CMD_PLEN) begin
              order_q[0] <= cur_q;
              cnt_q <= CW'(1);
            end
          end
        end
        cbpm_pkg::S_RD: begin
          if (byte_go) begin
            bi_q <= bi_q + FW'(1);
            total_q <= total_q + TW'(1);
            rvld_q <= 1'b1;
          end
        end
        cbpm_pkg::S_BYTE: begin
          if (byte_go) begin
            bi_q <= bi_q + FW'(1);
            total_q <= total_q + TW'(1);
            rvld_q <= 1'b1;
          end
          // pack the byte read last cycle; a full word is held back
          if (rvld_q) begin
            if (nb_q == 4'd7) begin
              pend_q   <= 1'b1;
              pend_w_q <= {rdata, word_q[55:0]};
              word_q   <= '0;
              nb_q     <= '0;
            end else begin
              word_q[nb_q[2:0]*8 +: 8] <= rdata;
              nb_q <= nb_q + 4'd1;
            end
          end
        end
        cbpm_pkg::S_FWD: begin
          bi_q <= '0;
          idx_q <= '0;
          if (fwd_go) begin
            cur_q  <= nl;
            seen_q <= seen_q | (N'(1) << nl);
            order_q[cnt_q[HW-1:0]] <= nl;
            cnt_q  <= cnt_q + CW'(1);
          end else if (pend_q) begin
            pend_q <= 1'b0;
            tail_q <= (nb_q != 4'd0);
          end
        end
        cbpm_pkg::S_FREE: begin
          tail_q <= 1'b0;
          alloc_q[order_q[idx_q[HW-1:0]]] <= 1'b0;
          if (idx_q == cnt_q - CW'(1)) begin
            next_q[order_q[idx_q[HW-1:0]]]    <= fhead_q;
            next_ok_q[order_q[idx_q[HW-1:0]]] <= fok_q;
            fhead_q <= order_q[0];
            fok_q   <= 1'b1;
            prev_ok_q[order_q[0]] <= 1'b0;
          end else begin
            next_q[order_q[idx_q[HW-1:0]]]    <= order_q[idx_q[HW-1:0] + HW'(1)];
            next_ok_q[order_q[idx_q[HW-1:0]]] <= 1'b1;
          end
          idx_q <= idx_q + CW'(1);
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_result_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.last |=> !valid_o || st_q != cbpm_pkg::S_IDLE ||
      $past(st_q) != cbpm_pkg::S_IDLE)
    else $error("two results after last");
  a_free_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == cbpm_pkg::S_IDLE && fok_q |-> !alloc_q[fhead_q])
    else $error("free head is allocated");
  a_bytes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_o.data_bytes <= 4'd8)
    else $error("byte count out of range");
`endif
endmodule
`default_nettype wire

@@ bench/tb_chained_buffer_pool_manager_unit.sv @@
// ----------------------------------------------------------------------------
// tb_chained_buffer_pool_manager_unit
// Self-checking bench for the chained buffer pool manager: a behavioural
// model of the pool predicts every result, a monitor compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_chained_buffer_pool_manager_unit;
  import cbpm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  cmd_t cmd_i = '0;
  logic busy_o, valid_o;
  res_t res_o;

  chained_buffer_pool_manager_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .cmd_i(cmd_i),
    .busy_o(busy_o), .valid_o(valid_o), .res_o(res_o)
  );

  // pool model state
  logic [7:0] pool_bytes [NumBuffers*BufBytes];
  logic       byte_known [NumBuffers*BufBytes];
  int unsigned nxt [NumBuffers];
  bit          nxt_ok [NumBuffers];
  int unsigned prv [NumBuffers];
  bit          prv_ok [NumBuffers];
  int unsigned fill [NumBuffers];
  bit          in_use [NumBuffers];
  int unsigned free_top;
  bit          free_top_ok;

  res_t expected_results [$];
  int   errors = 0;
  int   idle_pct = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  function automatic void pool_reset();
    for (int i = 0; i < NumBuffers; i++) begin
      nxt[i] = (i + 1) % NumBuffers;
      nxt_ok[i] = (i + 1) < NumBuffers;
      prv[i] = 0;
      prv_ok[i] = 0;
      fill[i] = 0;
      in_use[i] = 0;
    end
    for (int i = 0; i < NumBuffers*BufBytes; i++) begin
      pool_bytes[i] = '0;
      byte_known[i] = 0;
    end
    free_top = 0;
    free_top_ok = 1;
  endfunction

  function automatic res_t blank_res(status_e st);
    res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int pop_free(int unsigned after, bit linked);
    int unsigned n;
    if (!free_top_ok) return -1;
    n = free_top;
    free_top = nxt[n];
    free_top_ok = nxt_ok[n];
    in_use[n] = 1;
    fill[n] = 0;
    nxt_ok[n] = 0;
    if (linked) begin
      nxt[after] = n;
      nxt_ok[after] = 1;
      prv[n] = after;
      prv_ok[n] = 1;
    end else begin
      prv_ok[n] = 0;
    end
    return n;
  endfunction

  function automatic int unsigned chain_head(int unsigned h, output int unsigned steps);
    int unsigned seen, cur, p;
    seen = 1 << h;
    cur = h;
    steps = 0;
    while (prv_ok[cur]) begin
      p = prv[cur];
      if (!in_use[p] || seen[p]) break;
      seen |= 1 << p;
      cur = p;
      steps++;
    end
    return cur;
  endfunction

  // true when a commit from h would read a byte never written
  function automatic bit chain_has_hole(int unsigned h);
    int unsigned steps, cur, seen, cnt;
    cur = chain_head(h, steps);
    seen = 1 << cur;
    cnt = 0;
    forever begin
      cnt++;
      for (int i = 0; i < fill[cur]; i++)
        if (!byte_known[cur*BufBytes+i]) return 1;
      if (!nxt_ok[cur] || cnt >= NumBuffers) break;
      if (!in_use[nxt[cur]] || seen[nxt[cur]]) break;
      cur = nxt[cur];
      seen |= 1 << cur;
    end
    return 0;
  endfunction

  function automatic void predict_pool(cmd_t c);
    res_t r;
    int n;
    int unsigned h, pos, steps, head, cur, seen, cnt, nb, total, plen;
    int unsigned order [NumBuffers];
    logic [63:0] word;
    h = c.handle;
    if (c.command == CMD_FETCH) begin
      if (c.handle_valid && !in_use[h]) begin
        expected_results.push_back(blank_res(ST_BADH));
        return;
      end
      n = pop_free(h, c.handle_valid);
      if (n < 0) begin
        r = blank_res(ST_NOFREE);
      end else begin
        r = blank_res(ST_OK);
        r.new_handle = 3'(n);
      end
      expected_results.push_back(r);
      return;
    end
    if (!in_use[h]) begin
      expected_results.push_back(blank_res(ST_BADH));
      return;
    end
    case (c.command)
      CMD_APPEND: begin
        pos = c.position;
        if (pos >= BufBytes) begin
          n = pop_free(h, 1);
          if (n < 0) begin
            expected_results.push_back(blank_res(ST_NOFREE));
            return;
          end
          h = n;
          pos = 0;
        end
        pool_bytes[h*BufBytes+pos] = c.byte_value;
        byte_known[h*BufBytes+pos] = 1;
        if (fill[h] < pos + 1) fill[h] = pos + 1;
        r = blank_res(ST_OK);
        r.new_handle = 3'(h);
        r.new_position = 6'(pos + 1);
        expected_results.push_back(r);
      end
      CMD_COMMIT: begin
        head = chain_head(h, steps);
        cur = head;
        seen = 1 << head;
        cnt = 0; nb = 0; total = 0; word = '0;
        r = blank_res(ST_OK);
        r.last = 1'b0;
        forever begin
          order[cnt++] = cur;
          for (int i = 0; i < fill[cur] && total < WordCap*8; i++) begin
            word |= 64'(pool_bytes[cur*BufBytes+i]) << (8*nb);
            nb++;
            total++;
            if (nb == 8) begin
              r.data_word = word;
              r.data_bytes = 4'd8;
              expected_results.push_back(r);
              word = '0;
              nb = 0;
            end
          end
          if (!nxt_ok[cur] || cnt >= NumBuffers) break;
          n = nxt[cur];
          if (!in_use[n] || seen[n]) break;
          seen |= 1 << n;
          cur = n;
        end
        if (nb > 0 || total == 0) begin
          r.data_word = word;
          r.data_bytes = 4'(nb);
          r.last = 1'b1;
          expected_results.push_back(r);
        end else begin
          expected_results[$].last = 1'b1;
        end
        for (int i = 0; i < cnt; i++) begin
          in_use[order[i]] = 0;
          if (i + 1 < cnt) begin
            nxt[order[i]] = order[i+1];
            nxt_ok[order[i]] = 1;
          end else begin
            nxt[order[i]] = free_top;
            nxt_ok[order[i]] = free_top_ok;
          end
        end
        free_top = head;
        free_top_ok = 1;
        prv_ok[head] = 0;
      end
      default: begin
        void'(chain_head(h, steps));
        plen = steps * BufBytes;
        r = blank_res(ST_OK);
        r.prev_length = 8'(plen > 255 ? 255 : plen);
        expected_results.push_back(r);
      end
    endcase
  endfunction

  // drive one command, predicting at acceptance
  task automatic send_item(cmd_t c);
    @(negedge clk_i);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk_i);
    start_i <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_pool(c);
    @(negedge clk_i);
    start_i <= 1'b0;
    cmd_i.byte_value <= 8'($urandom);
  endtask

  function automatic cmd_t make_cmd(cmd_e op, int unsigned h, bit hv,
                                    int unsigned pos, int unsigned val);
    cmd_t c;
    c.command = op;
    c.handle = 3'(h);
    c.handle_valid = hv;
    c.position = 6'(pos);
    c.byte_value = 8'(val);
    return c;
  endfunction

  // compare each result against the oldest expectation
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, res_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (res_o.status !== e.status || res_o.new_handle !== e.new_handle ||
            res_o.new_position !== e.new_position ||
            res_o.data_word !== e.data_word || res_o.data_bytes !== e.data_bytes ||
            res_o.prev_length !== e.prev_length || res_o.last !== e.last) begin
          $display("%0t: mismatch expected %h actual %h", $realtime, e, res_o);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // pick a legal random command, keeping commits free of unwritten bytes
  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned h, k;
    c = cmd_t'(20'($urandom));
    h = $urandom_range(NumBuffers-1);
    k = $urandom_range(99);
    if (k >= 8) begin
      c.handle = 3'(h);
      if (k < 20) c.command = CMD_FETCH;
      else if (k < 75) c.command = CMD_APPEND;
      else if (k < 88) c.command = CMD_COMMIT;
      else c.command = CMD_PLEN;
      if (c.command == CMD_APPEND && in_use[h]) begin
        // extend the fill, open a new buffer or rewrite a byte already written
        c.position = ($urandom_range(9) == 0) ? 6'($urandom_range(32, 63)) :
                     6'(fill[h] < BufBytes ? fill[h] : BufBytes);
        if ($urandom_range(5) == 0 && fill[h] > 0)
          c.position = 6'($urandom_range(fill[h]-1));
      end
      if (c.command == CMD_APPEND && !in_use[h]) c.position = 6'($urandom_range(31));
    end
    if (c.command == CMD_COMMIT && in_use[c.handle] && chain_has_hole(c.handle))
      c.command = CMD_PLEN;
    return c;
  endfunction

  task automatic test_directed();
    int unsigned h;
    // bad handles on every command
    send_item(make_cmd(CMD_APPEND, 7, 0, 0, 8'hff));
    send_item(make_cmd(CMD_COMMIT, 0, 1, 63, 0));
    send_item(make_cmd(CMD_PLEN, 5, 1, 0, 0));
    send_item(make_cmd(CMD_FETCH, 3, 1, 0, 0));
    // empty chain commit
    send_item(make_cmd(CMD_FETCH, 0, 0, 0, 0));
    send_item(make_cmd(CMD_COMMIT, 0, 0, 0, 0));
    // fill the pool via overflowing appends, then exhaust it
    send_item(make_cmd(CMD_FETCH, 0, 0, 0, 0));
    h = expected_results[$].new_handle;
    for (int i = 0; i < 8; i++) begin
      send_item(make_cmd(CMD_APPEND, h, 0, i == 0 ? 0 : 63, 8'h00 + i*31));
      h = expected_results[$].new_handle;
    end
    send_item(make_cmd(CMD_FETCH, 0, 0, 0, 0));
    send_item(make_cmd(CMD_APPEND, h, 0, 63, 8'h55));
    send_item(make_cmd(CMD_PLEN, h, 0, 0, 0));
    send_item(make_cmd(CMD_APPEND, 0, 0, 1, 8'h80));
    send_item(make_cmd(CMD_COMMIT, 4, 0, 0, 0));
    wait_drained();
  endtask

  // long chain: previous length over the whole pool and a multi-word commit
  task automatic test_long_chain();
    int unsigned h;
    send_item(make_cmd(CMD_FETCH, 0, 0, 0, 0));
    h = expected_results[$].new_handle;
    for (int b = 0; b < NumBuffers; b++) begin
      for (int i = 0; i < BufBytes/4; i++) begin
        send_item(make_cmd(CMD_APPEND, h, 0, i == 0 && b > 0 ? 32 : i, $urandom));
        h = expected_results[$].new_handle;
      end
    end
    send_item(make_cmd(CMD_PLEN, h, 0, 0, 0));
    send_item(make_cmd(CMD_COMMIT, h, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) send_item(random_cmd());
    idle_pct = 0;
  endtask

  initial begin
    pool_reset();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_long_chain();
    test_random(80, 0);
    wait_drained();
    test_random(70, 52);
    test_random(70, 24);
    test_random(60, 0);
    wait_drained();
    repeat (200) @(negedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
